// ===== hdl/lrupr_pkg.sv =====
// Package: sizes, transaction payload types and cell control for the LRU replacement list.
`timescale 1ns / 1ps

package lrupr_pkg;

   localparam int DEPTH      = 16;
   localparam int FRAME_BITS = 20;
   localparam int IDX_BITS   = $clog2(DEPTH);
   localparam int CNT_BITS   = $clog2(DEPTH + 1);

   typedef enum logic {
      ACT_TOUCH = 1'b0,
      ACT_EVICT = 1'b1
   } action_type;

   typedef struct packed {
      action_type             action;
      logic [FRAME_BITS-1:0]  frame_number;
   } req_type;

   typedef struct packed {
      logic                   victim_valid;
      logic [FRAME_BITS-1:0]  victim_frame;
      logic                   was_present;
      logic                   overflow;
      logic [CNT_BITS-1:0]    occupancy;
   } rsp_type;

   // broadcast to every cell
   typedef struct packed {
      logic touch;    // accepted touch transaction this cycle
      logic any_hit;  // frame found in some occupied cell
      logic insert;   // new frame, room left
   } cell_ctl_type;

endpackage

// ===== hdl/lrupr_cell.sv =====
// One cell of the recency chain: holds a frame, compares it, shifts from its neighbor.
`timescale 1ns / 1ps

module lrupr_cell (
   input  logic                          clock,
   input  lrupr_pkg::cell_ctl_type       ctl,
   input  logic                          occupied,
   input  logic [lrupr_pkg::FRAME_BITS-1:0] key,
   input  logic [lrupr_pkg::FRAME_BITS-1:0] prev_data,
   input  logic                          hit_seen_in,
   output logic                          hit_seen_out,
   output logic                          hit,
   output logic [lrupr_pkg::FRAME_BITS-1:0] data
);
   import lrupr_pkg::*;

   logic [FRAME_BITS-1:0] data_ff;
   logic [FRAME_BITS-1:0] data_in;
   logic                  shift;

   assign hit          = occupied & (data_ff == key);
   assign hit_seen_out = hit_seen_in | hit;
   assign data         = data_ff;

   // shift down when the hit lies at or below this cell, or on an insert
   assign shift   = ctl.touch & ((ctl.any_hit & ~hit_seen_in) | ctl.insert);
   assign data_in = shift ? prev_data : data_ff;

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

// ===== hdl/lru_page_replacement_core.sv =====
// Top level: LRU replacement list built from a chain of frame cells.
`timescale 1ns / 1ps

// LRU page replacement list.
// Input channel req_*: one transaction carries an action and a frame number.
//   Touch moves a listed frame to the most-recent end or inserts a new one
//   there; evict removes the least-recent frame and returns it.
// Result channel rsp_*: exactly one result transaction per input transaction,
//   in order, with victim, was_present, overflow and the new occupancy.
// rsp_valid is set in the cycle after acceptance; unstalled, one transaction
//   per cycle; all cells compare the frame in parallel and shift in the same
//   edge, so the compare-and-shift through the cell chain sets the pace.
// A touch of a new frame on a full list is refused with overflow set.
// Stall: while a result is held under rsp_stall, req_stall is raised and the
//   list does not change; the result register holds its payload.
// Reset (synchronous, active high) empties the list and drops rsp_valid.
//   Cell contents are not cleared; occupancy alone decides which cells count.
module lru_page_replacement_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  lrupr_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output lrupr_pkg::rsp_type rsp_data
);
   import lrupr_pkg::*;

   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  accept;
   logic                  full;
   cell_ctl_type          ctl;
   logic [DEPTH-1:0]      hit_vec;
   logic [DEPTH:0]        seen_chain;
   logic [FRAME_BITS-1:0] cell_data [DEPTH];
   logic [CNT_BITS-1:0]   evict_sum;
   logic [IDX_BITS-1:0]   evict_idx;
   logic                  is_touch;

   // a held result blocks new input; an empty or draining register does not
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign is_touch  = (req_data.action == ACT_TOUCH);
   assign full      = (count_ff == CNT_BITS'(DEPTH));

   // end of the hit chain: some occupied cell matched
   assign ctl.touch   = accept & is_touch;
   assign ctl.any_hit = seen_chain[DEPTH];
   assign ctl.insert  = ~(|hit_vec) & ~full;

   assign seen_chain[0] = 1'b0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [FRAME_BITS-1:0] prev;
      if (i == 0) begin : g_head
         assign prev = req_data.frame_number;   // head takes the touched frame
      end else begin : g_body
         assign prev = cell_data[i-1];
      end
      lrupr_cell u_cell (
         .clock        (clock),
         .ctl          (ctl),
         .occupied     (CNT_BITS'(i) < count_ff),
         .key          (req_data.frame_number),
         .prev_data    (prev),
         .hit_seen_in  (seen_chain[i]),
         .hit_seen_out (seen_chain[i+1]),
         .hit          (hit_vec[i]),
         .data         (cell_data[i])
      );
   end

   // least-recent entry sits at count-1
   assign evict_sum = count_ff - CNT_BITS'(1);
   assign evict_idx = evict_sum[IDX_BITS-1:0];

   always_comb begin
      count_in = count_ff;
      rsp_in   = '0;
      if (is_touch) begin
         if (|hit_vec) begin
            rsp_in.was_present = 1'b1;
         end else if (!full) begin
            count_in = count_ff + CNT_BITS'(1);
         end else begin
            rsp_in.overflow = 1'b1;
         end
      end else if (count_ff != '0) begin
         rsp_in.victim_valid = 1'b1;
         rsp_in.victim_frame = cell_data[evict_idx];
         count_in            = evict_sum;
      end
      rsp_in.occupancy = count_in;
   end

   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== hdl/lrupr_checker.sv =====
// Checker on the top-level ports of the LRU list, bound to the top level.
`timescale 1ns / 1ps

module lrupr_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input lrupr_pkg::req_type req_data,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input lrupr_pkg::rsp_type rsp_data
);
   import lrupr_pkg::*;

   // every accepted transaction yields a result on the next cycle
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("no result after accepted transaction");

   // a touch never returns a victim
   a_touch_kind: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.action == ACT_TOUCH) |=> !rsp_data.victim_valid)
      else $error("victim reported for a touch");

   // result flags are mutually exclusive
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $countones({rsp_data.victim_valid, rsp_data.was_present,
                                rsp_data.overflow}) <= 1)
      else $error("conflicting result flags");

   // refusal happens only on a full list
   a_overflow: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.overflow) |-> rsp_data.occupancy == CNT_BITS'(DEPTH))
      else $error("overflow without full list");

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

endmodule

bind lru_page_replacement_core lrupr_checker u_lrupr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== verif/lru_page_replacement_core_test.sv =====
// Testbench: random and directed touch/evict traffic against a built-in LRU list predictor.
`timescale 1ns / 1ps

module lru_page_replacement_core_test;
   import lrupr_pkg::*;

   localparam int CLOCK_HALF   = 6;
   localparam int RESET_CYCLES = 6;
   localparam int RANDOM_ITEMS = 1750;
   localparam int IDLE_PCT     = 19;
   // No idling on either side inside this cycle window.
   localparam int QUIET_START  = 800;
   localparam int QUIET_END    = 1300;
   // Generous: ~1800 transactions, each under random stall on both sides.
   localparam int CYCLE_LIMIT  = 200000;
   localparam int TAIL_CYCLES  = 10;

   // One queued transaction; hold_for_drain makes the driver wait until
   // every outstanding result has come back before presenting it.
   typedef struct {
      req_type txn;
      bit      hold_for_drain;
   } queued_txn_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   queued_txn_type txn_queue[$];
   rsp_type        expected_results[$];
   int             mismatches  = 0;
   int             cycle_count = 0;

   // Predictor state: slot 0 is most recent, slot listed_count-1 least recent.
   logic [FRAME_BITS-1:0] lru_frames[DEPTH] = '{default: '0};
   int                    listed_count = 0;

   lru_page_replacement_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #CLOCK_HALF clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("lru_page_replacement_core_test: errors");
         $finish;
      end
   end

   // Random idle, suppressed in the quiet window.
   function automatic bit take_idle();
      if (cycle_count >= QUIET_START && cycle_count < QUIET_END)
         return 1'b0;
      return $urandom_range(0, 99) < IDLE_PCT;
   endfunction

   // Apply one transaction to the predicted list, return the result it yields.
   function automatic rsp_type lru_apply(req_type txn);
      rsp_type res;
      int      hit_pos;
      int      n;
      res     = '0;
      n       = listed_count;
      hit_pos = -1;
      if (txn.action == ACT_TOUCH) begin
         for (int i = 0; i < n; i++) begin
            if (hit_pos < 0 && lru_frames[i] == txn.frame_number)
               hit_pos = i;
         end
         if (hit_pos >= 0) begin
            // already listed: slide the newer entries down one, frame to front
            res.was_present = 1'b1;
            for (int i = hit_pos; i > 0; i--)
               lru_frames[i] = lru_frames[i-1];
            lru_frames[0] = txn.frame_number;
         end else if (n < DEPTH) begin
            for (int i = n; i > 0; i--)
               lru_frames[i] = lru_frames[i-1];
            lru_frames[0] = txn.frame_number;
            n++;
         end else begin
            // new frame, list full: refused, list untouched
            res.overflow = 1'b1;
         end
      end else if (n > 0) begin
         res.victim_valid = 1'b1;
         res.victim_frame = lru_frames[n-1];
         n--;
      end
      // evict on an empty list: all zero, nothing changes
      listed_count  = n;
      res.occupancy = CNT_BITS'(n);
      return res;
   endfunction

   task automatic queue_txn(action_type act, logic [FRAME_BITS-1:0] frame, bit drain);
      queued_txn_type q;
      q.txn.action       = act;
      q.txn.frame_number = frame;
      q.hold_for_drain   = drain;
      txn_queue.push_back(q);
   endtask

   task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch %0s: expected %0h actual %0h at cycle %0d",
                     field, want, got, cycle_count);
      end
   endtask

   // Driver: a transaction is accepted at an edge with req_valid high and
   // req_stall low. Once raised, valid and payload hold until accepted.
   always @(posedge clock) begin : driver
      logic accepted;
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
      end else begin
         accepted = req_valid && !req_stall;
         if (accepted) begin
            expected_results.push_back(lru_apply(req_data));
            void'(txn_queue.pop_front());
         end
         if (!req_valid || accepted) begin
            if (txn_queue.size() > 0 && !take_idle() &&
                (!txn_queue[0].hold_for_drain || expected_results.size() == 0)) begin
               req_valid <= 1'b1;
               req_data  <= txn_queue[0].txn;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each accepted result with the oldest expectation.
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result %0h at cycle %0d", rsp_data, cycle_count);
            end else begin
               want = expected_results.pop_front();
               check_field("victim_valid", 32'(want.victim_valid),
                           32'(rsp_data.victim_valid));
               check_field("victim_frame", 32'(want.victim_frame),
                           32'(rsp_data.victim_frame));
               check_field("was_present",  32'(want.was_present),
                           32'(rsp_data.was_present));
               check_field("overflow",     32'(want.overflow),
                           32'(rsp_data.overflow));
               check_field("occupancy",    32'(want.occupancy),
                           32'(rsp_data.occupancy));
            end
         end
         rsp_stall <= take_idle();
      end
   end

   initial begin : stimulus
      logic [FRAME_BITS-1:0] frame_pool[24];
      int                    evict_pct;
      int                    issued;
      logic [FRAME_BITS-1:0] frame;
      action_type            act;

      reset = 1'b1;

      // Directed: evict on empty, extreme frames, hit at the tail of a short
      // list, fill to full, refused touch on full list, hit at the tail, evicts.
      queue_txn(ACT_EVICT, '1, 1'b0);
      queue_txn(ACT_TOUCH, '0, 1'b0);
      queue_txn(ACT_TOUCH, '1, 1'b0);
      queue_txn(ACT_TOUCH, '0, 1'b0);
      for (int i = 1; i <= 14; i++)
         queue_txn(ACT_TOUCH, FRAME_BITS'(i * 20'h11111), 1'b0);
      queue_txn(ACT_TOUCH, 20'h5A5A5, 1'b0);   // list full: overflow
      queue_txn(ACT_TOUCH, '1, 1'b1);          // least recent entry, after a drain
      queue_txn(ACT_EVICT, '0, 1'b0);
      queue_txn(ACT_EVICT, 20'hABCDE, 1'b0);

      // Random: segments with a changing evict mix so the list swings between
      // empty and full; frames come mostly from a small pool to get hits.
      issued = 0;
      while (issued < RANDOM_ITEMS) begin
         for (int i = 0; i < 24; i++)
            if (issued == 0 || $urandom_range(0, 3) == 0)
               frame_pool[i] = FRAME_BITS'($urandom_range(0, (1 << FRAME_BITS) - 1));
         case ($urandom_range(0, 4))
            0: evict_pct = 5;
            1: evict_pct = 25;
            2: evict_pct = 45;
            3: evict_pct = 60;
            default: evict_pct = 85;
         endcase
         for (int k = 0; k < 50; k++) begin
            act = ($urandom_range(0, 99) < evict_pct) ? ACT_EVICT : ACT_TOUCH;
            if ($urandom_range(0, 9) < 7)
               frame = frame_pool[$urandom_range(0, 23)];
            else
               frame = FRAME_BITS'($urandom_range(0, (1 << FRAME_BITS) - 1));
            queue_txn(act, frame, (issued % 400) == 399);
            issued++;
         end
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (txn_queue.size() > 0 || expected_results.size() > 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("lru_page_replacement_core_test: clean");
      end else begin
         $display("lru_page_replacement_core_test: errors");
      end
      $finish;
   end

endmodule
